FILE: sv/sftp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFTP request parser package
// Shared types, phase codes, request type codes and result tags.
// ----------------------------------------------------------------------------
package sftp_pkg;

    localparam int HANDLE_BYTES_DEFAULT  = 8;
    localparam int PATH_CAPACITY_DEFAULT = 256;
    localparam logic [31:0] MAX_BODY_RESET = 32'd65536;

    typedef enum logic [5:0] {
        PH_LEN, PH_TYPE, PH_ID, PH_PATH_LEN, PH_PATH_BYTES, PH_PATH2_LEN,
        PH_PATH2_BYTES, PH_PFLAGS, PH_HLEN, PH_HBYTES, PH_OFFSET, PH_RLEN,
        PH_DLEN, PH_DBYTES, PH_AFLAGS, PH_ASIZE, PH_AUID, PH_AGID, PH_APERM,
        PH_AATIME, PH_AMTIME, PH_ECOUNT, PH_EKLEN, PH_EKBYTES, PH_EVLEN,
        PH_EVBYTES, PH_DONE, PH_SKIP
    } phase_t;

    localparam logic [7:0] T_INIT = 8'd1;
    localparam logic [7:0] T_OPEN = 8'd3;
    localparam logic [7:0] T_CLOSE = 8'd4;
    localparam logic [7:0] T_READ = 8'd5;
    localparam logic [7:0] T_WRITE = 8'd6;
    localparam logic [7:0] T_LSTAT = 8'd7;
    localparam logic [7:0] T_FSTAT = 8'd8;
    localparam logic [7:0] T_SETSTAT = 8'd9;
    localparam logic [7:0] T_FSETSTAT = 8'd10;
    localparam logic [7:0] T_OPENDIR = 8'd11;
    localparam logic [7:0] T_READDIR = 8'd12;
    localparam logic [7:0] T_REMOVE = 8'd13;
    localparam logic [7:0] T_MKDIR = 8'd14;
    localparam logic [7:0] T_RMDIR = 8'd15;
    localparam logic [7:0] T_REALPATH = 8'd16;
    localparam logic [7:0] T_STAT = 8'd17;
    localparam logic [7:0] T_RENAME = 8'd18;
    localparam logic [7:0] T_READLINK = 8'd19;
    localparam logic [7:0] T_SYMLINK = 8'd20;

    localparam logic [4:0] TAG_TYPE = 5'd0;
    localparam logic [4:0] TAG_ID = 5'd1;
    localparam logic [4:0] TAG_PFLAGS = 5'd2;
    localparam logic [4:0] TAG_HANDLE = 5'd3;
    localparam logic [4:0] TAG_OFFSET = 5'd4;
    localparam logic [4:0] TAG_RLEN = 5'd5;
    localparam logic [4:0] TAG_PATH = 5'd6;
    localparam logic [4:0] TAG_PATH2 = 5'd7;
    localparam logic [4:0] TAG_DATA = 5'd8;
    localparam logic [4:0] TAG_AFLAGS = 5'd9;
    localparam logic [4:0] TAG_SIZE = 5'd10;
    localparam logic [4:0] TAG_UID = 5'd11;
    localparam logic [4:0] TAG_GID = 5'd12;
    localparam logic [4:0] TAG_PERM = 5'd13;
    localparam logic [4:0] TAG_ATIME = 5'd14;
    localparam logic [4:0] TAG_MTIME = 5'd15;
    localparam logic [4:0] TAG_END = 5'd16;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_tag;
        logic [63:0] field_value;
        logic [1:0]  parse_status;
        logic        run_last;
    } out_item_t;

endpackage

FILE: sv/sftp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFTP stream interfaces
// Valid/ready channels for input bytes and parsed result items.
// ----------------------------------------------------------------------------
interface sftp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       buffer_end;
    modport source (output valid, output in_byte, output buffer_end, input ready);
    modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface sftp_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_tag;
    logic [63:0] field_value;
    logic [1:0]  parse_status;
    logic        run_last;
    modport source (output valid, output field_tag, output field_value,
                    output parse_status, output run_last, input ready);
    modport sink (input valid, input field_tag, input field_value,
                  input parse_status, input run_last, output ready);
endinterface

FILE: sv/sftp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFTP result queue
// Small queue that takes up to two results per cycle and issues one.
// ----------------------------------------------------------------------------
module sftp_out_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_count,
    input  sftp_pkg::out_item_t push_a,
    input  sftp_pkg::out_item_t push_b,
    output logic                room,
    output logic                valid,
    output sftp_pkg::out_item_t head,
    input  logic                pop
);
    import sftp_pkg::*;

    localparam int DEPTH = 4;

    out_item_t  mem_reg [DEPTH];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign do_pop = pop && (cnt_reg != 3'd0);
    assign valid  = cnt_reg != 3'd0;
    assign head   = mem_reg[rd_reg];
    // Room for two pushes regardless of a pop this cycle.
    assign room   = cnt_reg <= 3'd2;

    always_comb
    begin
        rd_next  = rd_reg + {1'b0, do_pop};
        wr_next  = wr_reg + push_count;
        cnt_next = cnt_reg + {1'b0, push_count} - {2'b00, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_reg] <= push_a;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_reg + 2'd1] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: sv/sftp_request_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFTP request parser
// Parses SFTP version 3 request packets one byte at a time into tagged fields.
//
// Bytes arrive on in_ch, one transfer per byte; buffer_end marks the last
// byte of a buffer. Each byte updates a field state machine and yields zero,
// one or two results (a field and, on buffer_end, the end result with its
// status). Results go into a four-entry queue that drives out_ch.
// Throughput is one byte per cycle while the queue has room for two results.
// When the receiver stalls, the queue fills and in_ch.ready drops until two
// slots are free again. Reset empties the queue, returns the parser to the
// length prefix and sets max_body to 65536. The user must write max_body through
// cfg_we/cfg_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module sftp_request_parser
#(
    parameter int HANDLE_BYTES  = sftp_pkg::HANDLE_BYTES_DEFAULT,
    parameter int PATH_CAPACITY = sftp_pkg::PATH_CAPACITY_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    sftp_in_if.sink     in_ch,
    sftp_out_if.source  out_ch
);
    import sftp_pkg::*;

    phase_t      ph_reg, ph_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] body_reg, body_next;
    logic [7:0]  rtype_reg, rtype_next;
    logic [31:0] aflag_reg, aflag_next;
    logic [31:0] srem_reg, srem_next;
    logic [31:0] epairs_reg, epairs_next;
    logic [1:0]  err_reg, err_next;
    logic [31:0] max_body_reg;

    logic        accept;
    logic        room;
    logic [1:0]  n;
    out_item_t   ra, rb, res;
    logic        has_field;
    out_item_t   fld;
    logic [63:0] tk;
    logic [3:0]  tcnt;
    logic [31:0] len;
    logic [31:0] brem;
    logic [1:0]  status;
    logic [7:0]  b;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = room;
    assign b = in_ch.in_byte;
    assign tk = {acc_reg[55:0], b};
    assign tcnt = fcnt_reg + 4'd1;
    assign len = tk[31:0];

    function automatic phase_t attr_from(input logic [2:0] stage, input logic [31:0] f);
        phase_t p;
        if (stage <= 3'd0 && f[0])
            p = PH_ASIZE;
        else if (stage <= 3'd1 && f[1])
            p = PH_AUID;
        else if (stage <= 3'd2 && f[2])
            p = PH_APERM;
        else if (stage <= 3'd3 && f[3])
            p = PH_AATIME;
        else if (stage <= 3'd4 && f[31])
            p = PH_ECOUNT;
        else
            p = PH_DONE;
        return p;
    endfunction

    function automatic phase_t after_path(input logic second, input logic [7:0] t);
        phase_t p;
        p = PH_DONE;
        if (!second)
        begin
            if (t == T_OPEN)
                p = PH_PFLAGS;
            else if (t == T_SETSTAT || t == T_MKDIR)
                p = PH_AFLAGS;
            else if (t == T_RENAME || t == T_SYMLINK)
                p = PH_PATH2_LEN;
        end
        return p;
    endfunction

    always_comb
    begin
        ph_next     = ph_reg;
        fcnt_next   = fcnt_reg;
        acc_next    = acc_reg;
        body_next   = body_reg;
        rtype_next  = rtype_reg;
        aflag_next  = aflag_reg;
        srem_next   = srem_reg;
        epairs_next = epairs_reg;
        err_next    = err_reg;
        has_field   = 1'b0;
        fld         = '0;
        brem        = body_reg - 32'd1;
        status      = ST_OK;

        if (ph_reg == PH_LEN)
        begin
            acc_next  = tk;
            fcnt_next = tcnt;
            if (tcnt >= 4'd4)
            begin
                fcnt_next = '0;
                acc_next  = '0;
                if (len == 32'd0)
                begin
                    err_next = ST_INVALID;
                    ph_next  = PH_SKIP;
                end
                else if (len > max_body_reg)
                begin
                    err_next = ST_LONG;
                    ph_next  = PH_SKIP;
                end
                else
                begin
                    body_next = len;
                    ph_next   = PH_TYPE;
                end
            end
        end
        else if (ph_reg == PH_SKIP)
        begin
        end
        else if (body_reg == 32'd0)
        begin
            err_next = ST_INVALID;
            ph_next = PH_SKIP;
            fcnt_next = '0;
            acc_next = '0;
        end
        else
        begin
            body_next = brem;
            // Default for multi-byte fields: keep accumulating.
            acc_next  = tk;
            fcnt_next = tcnt;
            case (ph_reg)
                PH_TYPE:
                begin
                    rtype_next = b;
                    has_field = 1'b1;
                    fld.field_tag = TAG_TYPE;
                    fld.field_value = {56'd0, b};
                    ph_next = PH_ID; fcnt_next = '0; acc_next = '0;
                end
                PH_ID:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        has_field = 1'b1;
                        fld.field_tag = TAG_ID;
                        fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0;
                        case (rtype_reg)
                            T_OPEN, T_SETSTAT, T_MKDIR, T_RENAME, T_SYMLINK, T_LSTAT,
                            T_STAT, T_OPENDIR, T_REMOVE, T_RMDIR, T_REALPATH,
                            T_READLINK: ph_next = PH_PATH_LEN;
                            T_CLOSE, T_FSTAT, T_READDIR, T_READ, T_WRITE,
                            T_FSETSTAT: ph_next = PH_HLEN;
                            default: ph_next = PH_DONE;
                        endcase
                    end
                end
                PH_PATH_LEN, PH_PATH2_LEN:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        fcnt_next = '0; acc_next = '0;
                        if (len >= 32'(PATH_CAPACITY) || len > brem)
                        begin
                            err_next = ST_INVALID; ph_next = PH_SKIP;
                        end
                        else if (len == 32'd0)
                            ph_next = after_path(ph_reg == PH_PATH2_LEN, rtype_reg);
                        else
                        begin
                            srem_next = len;
                            ph_next = (ph_reg == PH_PATH2_LEN) ? PH_PATH2_BYTES
                                                               : PH_PATH_BYTES;
                        end
                    end
                end
                PH_PATH_BYTES, PH_PATH2_BYTES:
                begin
                    acc_next = acc_reg; fcnt_next = fcnt_reg;
                    if (b == 8'd0)
                    begin
                        err_next = ST_INVALID; ph_next = PH_SKIP;
                        fcnt_next = '0; acc_next = '0;
                    end
                    else
                    begin
                        has_field = 1'b1;
                        fld.field_tag = (ph_reg == PH_PATH2_BYTES) ? TAG_PATH2 : TAG_PATH;
                        fld.field_value = {56'd0, b};
                        srem_next = srem_reg - 32'd1;
                        if (srem_reg == 32'd1)
                        begin
                            ph_next = after_path(ph_reg == PH_PATH2_BYTES, rtype_reg);
                            fcnt_next = '0; acc_next = '0;
                        end
                    end
                end
                PH_PFLAGS:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_PFLAGS; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = PH_AFLAGS;
                    end
                end
                PH_HLEN:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        fcnt_next = '0; acc_next = '0;
                        if (tk != 64'(HANDLE_BYTES))
                        begin
                            err_next = ST_INVALID; ph_next = PH_SKIP;
                        end
                        else
                            ph_next = PH_HBYTES;
                    end
                end
                PH_HBYTES:
                begin
                    if (tcnt >= 4'(HANDLE_BYTES))
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_HANDLE; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0;
                        if (rtype_reg == T_READ || rtype_reg == T_WRITE)
                            ph_next = PH_OFFSET;
                        else if (rtype_reg == T_FSETSTAT)
                            ph_next = PH_AFLAGS;
                        else
                            ph_next = PH_DONE;
                    end
                end
                PH_OFFSET:
                begin
                    if (tcnt >= 4'd8)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_OFFSET; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0;
                        ph_next = (rtype_reg == T_READ) ? PH_RLEN : PH_DLEN;
                    end
                end
                PH_RLEN:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_RLEN; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = PH_DONE;
                    end
                end
                PH_DLEN:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        fcnt_next = '0; acc_next = '0;
                        if (len > max_body_reg || len > brem)
                        begin
                            err_next = ST_INVALID; ph_next = PH_SKIP;
                        end
                        else if (len == 32'd0)
                            ph_next = PH_DONE;
                        else
                        begin
                            srem_next = len; ph_next = PH_DBYTES;
                        end
                    end
                end
                PH_DBYTES:
                begin
                    acc_next = acc_reg; fcnt_next = fcnt_reg;
                    has_field = 1'b1; fld.field_tag = TAG_DATA;
                    fld.field_value = {56'd0, b};
                    srem_next = srem_reg - 32'd1;
                    if (srem_reg == 32'd1)
                    begin
                        ph_next = PH_DONE; fcnt_next = '0; acc_next = '0;
                    end
                end
                PH_AFLAGS:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        aflag_next = len;
                        has_field = 1'b1; fld.field_tag = TAG_AFLAGS; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = attr_from(3'd0, len);
                    end
                end
                PH_ASIZE:
                begin
                    if (tcnt >= 4'd8)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_SIZE; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = attr_from(3'd1, aflag_reg);
                    end
                end
                PH_AUID:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_UID; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = PH_AGID;
                    end
                end
                PH_AGID:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_GID; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = attr_from(3'd2, aflag_reg);
                    end
                end
                PH_APERM:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_PERM; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = attr_from(3'd3, aflag_reg);
                    end
                end
                PH_AATIME:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_ATIME; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = PH_AMTIME;
                    end
                end
                PH_AMTIME:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        has_field = 1'b1; fld.field_tag = TAG_MTIME; fld.field_value = tk;
                        fcnt_next = '0; acc_next = '0; ph_next = attr_from(3'd4, aflag_reg);
                    end
                end
                PH_ECOUNT:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        fcnt_next = '0; acc_next = '0;
                        if ({len, 3'b000} > {3'b000, brem})
                        begin
                            err_next = ST_INVALID; ph_next = PH_SKIP;
                        end
                        else if (len == 32'd0)
                            ph_next = PH_DONE;
                        else
                        begin
                            epairs_next = len; ph_next = PH_EKLEN;
                        end
                    end
                end
                PH_EKLEN, PH_EVLEN:
                begin
                    if (tcnt >= 4'd4)
                    begin
                        fcnt_next = '0; acc_next = '0;
                        if (len > brem)
                        begin
                            err_next = ST_INVALID; ph_next = PH_SKIP;
                        end
                        else if (len == 32'd0)
                        begin
                            if (ph_reg == PH_EKLEN)
                                ph_next = PH_EVLEN;
                            else
                            begin
                                epairs_next = epairs_reg - 32'd1;
                                ph_next = (epairs_reg == 32'd1) ? PH_DONE : PH_EKLEN;
                            end
                        end
                        else
                        begin
                            srem_next = len;
                            ph_next = (ph_reg == PH_EVLEN) ? PH_EVBYTES : PH_EKBYTES;
                        end
                    end
                end
                PH_EKBYTES, PH_EVBYTES:
                begin
                    acc_next = acc_reg; fcnt_next = fcnt_reg;
                    srem_next = srem_reg - 32'd1;
                    if (srem_reg == 32'd1)
                    begin
                        fcnt_next = '0; acc_next = '0;
                        if (ph_reg == PH_EKBYTES)
                            ph_next = PH_EVLEN;
                        else
                        begin
                            epairs_next = epairs_reg - 32'd1;
                            ph_next = (epairs_reg == 32'd1) ? PH_DONE : PH_EKLEN;
                        end
                    end
                end
                default:
                begin
                    acc_next = acc_reg; fcnt_next = fcnt_reg;
                end
            endcase
            if (ph_next != PH_DONE && ph_next != PH_SKIP && brem == 32'd0)
            begin
                err_next = ST_INVALID; ph_next = PH_SKIP;
                fcnt_next = '0; acc_next = '0;
            end
        end

        if (ph_next == PH_LEN)
            status = ST_SHORT;
        else if (err_next != ST_OK)
            status = err_next;
        else if (body_next != 32'd0)
            status = ST_INVALID;
        else
            status = ST_OK;

        if (in_ch.buffer_end)
        begin
            ph_next = PH_LEN; fcnt_next = '0; acc_next = '0; body_next = '0;
            rtype_next = '0; aflag_next = '0; srem_next = '0; epairs_next = '0;
            err_next = ST_OK;
        end
    end

    always_comb
    begin
        res.field_tag    = TAG_END;
        res.field_value  = '0;
        res.parse_status = status;
        res.run_last     = 1'b1;
        ra = has_field ? fld : res;
        rb = res;
        n  = 2'd0;
        if (accept)
            n = {1'b0, has_field} + {1'b0, in_ch.buffer_end};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_LEN; fcnt_reg <= '0; acc_reg <= '0; body_reg <= '0;
            rtype_reg <= '0; aflag_reg <= '0; srem_reg <= '0; epairs_reg <= '0;
            err_reg <= '0; max_body_reg <= MAX_BODY_RESET;
        end
        else
        begin
            if (cfg_we)
                max_body_reg <= cfg_data;
            if (accept)
            begin
                ph_reg <= ph_next; fcnt_reg <= fcnt_next; acc_reg <= acc_next;
                body_reg <= body_next; rtype_reg <= rtype_next;
                aflag_reg <= aflag_next; srem_reg <= srem_next;
                epairs_reg <= epairs_next; err_reg <= err_next;
            end
        end
    end

    out_item_t head;

    sftp_out_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (n),
        .push_a     (ra),
        .push_b     (rb),
        .room       (room),
        .valid      (out_ch.valid),
        .head       (head),
        .pop        (out_ch.ready)
    );

    assign out_ch.field_tag    = head.field_tag;
    assign out_ch.field_value  = head.field_value;
    assign out_ch.parse_status = head.parse_status;
    assign out_ch.run_last     = head.run_last;
endmodule

FILE: tb/tb_sftp_request_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SFTP request parser testbench
// Feeds framed SFTP v3 requests, well formed and broken, into the parser one
// byte per transfer. A predictor tracks the parse state, and every result
// transfer is checked against the oldest predicted field. Both sides idle at
// random, and max_body is changed between phases while the parser is idle.
// ----------------------------------------------------------------------------
module tb_sftp_request_parser;
    import sftp_pkg::*;

    localparam int HBYTES = HANDLE_BYTES_DEFAULT;
    localparam int PCAP = PATH_CAPACITY_DEFAULT;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;

    sftp_in_if  in_ch ();
    sftp_out_if out_ch ();

    sftp_request_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    in_item_t  pending_bytes[$];
    out_item_t expected_fields[$];
    logic [7:0] body_q[$];
    int        mismatches;
    int        hold_seq;
    int        bytes_queued;

    // Parser state of the predictor.
    phase_t      ph;
    logic [3:0]  fcnt;
    logic [63:0] acc;
    logic [31:0] body_rem;
    logic [7:0]  rtype;
    logic [31:0] aflags;
    logic [31:0] str_rem;
    logic [31:0] ext_left;
    logic [1:0]  err;
    logic [31:0] max_body;
    int          step_n;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic expect_field(input logic [4:0] tag, input logic [63:0] value,
                                input logic [1:0] status, input logic last);
        out_item_t o;
        o.field_tag = tag;
        o.field_value = value;
        o.parse_status = status;
        o.run_last = last;
        if (step_n < 2)
            expected_fields.push_back(o);
        step_n++;
    endtask

    task automatic goto(input phase_t p);
        ph = p;
        fcnt = '0;
        acc = '0;
    endtask

    task automatic fail_pkt();
        err = ST_INVALID;
        goto(PH_SKIP);
    endtask

    function automatic bit take_byte(input logic [7:0] b, input int n);
        acc = {acc[55:0], b};
        fcnt = fcnt + 4'd1;
        return fcnt >= n;
    endfunction

    function automatic phase_t attr_next(input int stage);
        if (stage <= 0 && aflags[0]) return PH_ASIZE;
        if (stage <= 1 && aflags[1]) return PH_AUID;
        if (stage <= 2 && aflags[2]) return PH_APERM;
        if (stage <= 3 && aflags[3]) return PH_AATIME;
        if (stage <= 4 && aflags[31]) return PH_ECOUNT;
        return PH_DONE;
    endfunction

    task automatic after_path(input bit second);
        if (second)
            goto(PH_DONE);
        else
            case (rtype)
                T_OPEN: goto(PH_PFLAGS);
                T_SETSTAT, T_MKDIR: goto(PH_AFLAGS);
                T_RENAME, T_SYMLINK: goto(PH_PATH2_LEN);
                default: goto(PH_DONE);
            endcase
    endtask

    task automatic ext_done(input bit value_part);
        if (!value_part)
            goto(PH_EVLEN);
        else
        begin
            ext_left--;
            goto(ext_left == 0 ? PH_DONE : PH_EKLEN);
        end
    endtask

    task automatic parse_body_byte(input logic [7:0] b);
        logic [31:0] len;
        bit second;
        case (ph)
            PH_TYPE:
            begin
                rtype = b;
                expect_field(TAG_TYPE, {56'd0, b}, ST_OK, 1'b0);
                goto(PH_ID);
            end
            PH_ID:
                if (take_byte(b, 4))
                begin
                    expect_field(TAG_ID, acc, ST_OK, 1'b0);
                    case (rtype)
                        T_OPEN, T_SETSTAT, T_MKDIR, T_RENAME, T_SYMLINK, T_LSTAT,
                        T_STAT, T_OPENDIR, T_REMOVE, T_RMDIR, T_REALPATH,
                        T_READLINK: goto(PH_PATH_LEN);
                        T_CLOSE, T_FSTAT, T_READDIR, T_READ, T_WRITE,
                        T_FSETSTAT: goto(PH_HLEN);
                        default: goto(PH_DONE);
                    endcase
                end
            PH_PATH_LEN, PH_PATH2_LEN:
                if (take_byte(b, 4))
                begin
                    len = acc[31:0];
                    second = (ph == PH_PATH2_LEN);
                    if (len >= PCAP || len > body_rem)
                        fail_pkt();
                    else if (len == 0)
                        after_path(second);
                    else
                    begin
                        str_rem = len;
                        goto(second ? PH_PATH2_BYTES : PH_PATH_BYTES);
                    end
                end
            PH_PATH_BYTES, PH_PATH2_BYTES:
            begin
                second = (ph == PH_PATH2_BYTES);
                if (b == 8'd0)
                    fail_pkt();
                else
                begin
                    expect_field(second ? TAG_PATH2 : TAG_PATH, {56'd0, b}, ST_OK, 1'b0);
                    str_rem--;
                    if (str_rem == 0)
                        after_path(second);
                end
            end
            PH_PFLAGS:
                if (take_byte(b, 4))
                begin
                    expect_field(TAG_PFLAGS, acc, ST_OK, 1'b0);
                    goto(PH_AFLAGS);
                end
            PH_HLEN:
                if (take_byte(b, 4))
                begin
                    if (acc != HBYTES)
                        fail_pkt();
                    else
                        goto(PH_HBYTES);
                end
            PH_HBYTES:
                if (take_byte(b, HBYTES))
                begin
                    expect_field(TAG_HANDLE, acc, ST_OK, 1'b0);
                    case (rtype)
                        T_READ, T_WRITE: goto(PH_OFFSET);
                        T_FSETSTAT: goto(PH_AFLAGS);
                        default: goto(PH_DONE);
                    endcase
                end
            PH_OFFSET:
                if (take_byte(b, 8))
                begin
                    expect_field(TAG_OFFSET, acc, ST_OK, 1'b0);
                    goto(rtype == T_READ ? PH_RLEN : PH_DLEN);
                end
            PH_RLEN:
                if (take_byte(b, 4))
                begin
                    expect_field(TAG_RLEN, acc, ST_OK, 1'b0);
                    goto(PH_DONE);
                end
            PH_DLEN:
                if (take_byte(b, 4))
                begin
                    len = acc[31:0];
                    if (len > max_body || len > body_rem)
                        fail_pkt();
                    else if (len == 0)
                        goto(PH_DONE);
                    else
                    begin
                        str_rem = len;
                        goto(PH_DBYTES);
                    end
                end
            PH_DBYTES:
            begin
                expect_field(TAG_DATA, {56'd0, b}, ST_OK, 1'b0);
                str_rem--;
                if (str_rem == 0)
                    goto(PH_DONE);
            end
            PH_AFLAGS:
                if (take_byte(b, 4))
                begin
                    aflags = acc[31:0];
                    expect_field(TAG_AFLAGS, acc, ST_OK, 1'b0);
                    goto(attr_next(0));
                end
            PH_ASIZE:
                if (take_byte(b, 8))
                begin
                    expect_field(TAG_SIZE, acc, ST_OK, 1'b0);
                    goto(attr_next(1));
                end
            PH_AUID:
                if (take_byte(b, 4))
                begin
                    expect_field(TAG_UID, acc, ST_OK, 1'b0);
                    goto(PH_AGID);
                end
            PH_AGID:
                if (take_byte(b, 4))
                begin
                    expect_field(TAG_GID, acc, ST_OK, 1'b0);
                    goto(attr_next(2));
                end
            PH_APERM:
                if (take_byte(b, 4))
                begin
                    expect_field(TAG_PERM, acc, ST_OK, 1'b0);
                    goto(attr_next(3));
                end
            PH_AATIME:
                if (take_byte(b, 4))
                begin
                    expect_field(TAG_ATIME, acc, ST_OK, 1'b0);
                    goto(PH_AMTIME);
                end
            PH_AMTIME:
                if (take_byte(b, 4))
                begin
                    expect_field(TAG_MTIME, acc, ST_OK, 1'b0);
                    goto(attr_next(4));
                end
            PH_ECOUNT:
                if (take_byte(b, 4))
                begin
                    len = acc[31:0];
                    if ({32'd0, len} * 64'd8 > {32'd0, body_rem})
                        fail_pkt();
                    else if (len == 0)
                        goto(PH_DONE);
                    else
                    begin
                        ext_left = len;
                        goto(PH_EKLEN);
                    end
                end
            PH_EKLEN, PH_EVLEN:
                if (take_byte(b, 4))
                begin
                    len = acc[31:0];
                    second = (ph == PH_EVLEN);
                    if (len > body_rem)
                        fail_pkt();
                    else if (len == 0)
                        ext_done(second);
                    else
                    begin
                        str_rem = len;
                        goto(second ? PH_EVBYTES : PH_EKBYTES);
                    end
                end
            PH_EKBYTES, PH_EVBYTES:
            begin
                str_rem--;
                if (str_rem == 0)
                    ext_done(ph == PH_EVBYTES);
            end
            default: ;
        endcase
    endtask

    task automatic clear_parse();
        goto(PH_LEN);
        body_rem = '0;
        rtype = '0;
        aflags = '0;
        str_rem = '0;
        ext_left = '0;
        err = '0;
    endtask

    task automatic predict_transfer(input in_item_t it);
        logic [1:0] status;
        step_n = 0;
        if (ph == PH_LEN)
        begin
            if (take_byte(it.in_byte, 4))
            begin
                if (acc[31:0] == 0)
                begin
                    err = ST_INVALID;
                    goto(PH_SKIP);
                end
                else if (acc[31:0] > max_body)
                begin
                    err = ST_LONG;
                    goto(PH_SKIP);
                end
                else
                begin
                    body_rem = acc[31:0];
                    goto(PH_TYPE);
                end
            end
        end
        else if (ph == PH_SKIP)
            ;
        else if (body_rem == 0)
            fail_pkt();
        else
        begin
            body_rem--;
            parse_body_byte(it.in_byte);
            if (ph != PH_DONE && ph != PH_SKIP && body_rem == 0)
                fail_pkt();
        end
        if (it.buffer_end)
        begin
            if (ph == PH_LEN)
                status = ST_SHORT;
            else if (err != 0)
                status = err;
            else if (body_rem != 0)
                status = ST_INVALID;
            else
                status = ST_OK;
            expect_field(TAG_END, 64'd0, status, 1'b1);
            clear_parse();
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_transfer('{in_byte: in_ch.in_byte, buffer_end: in_ch.buffer_end});
            if (in_ch.valid && !in_ch.ready)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                in_item_t nx;
                nx = pending_bytes.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.in_byte <= nx.in_byte;
                in_ch.buffer_end <= nx.buffer_end;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: a randomly chosen stall pattern that changes periodically, plus a long hold-off.
    int hold_seen;
    int hold_cnt;
    int ready_mode;
    int ready_cyc;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_seen = 0;
            hold_cnt = 0;
            ready_mode = 0;
            ready_cyc = 0;
        end
        else
        begin
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_cnt = 300;
            end
            ready_cyc++;
            if (ready_cyc % 64 == 0)
                ready_mode = $urandom_range(0, 3);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end
            else if (ready_mode == 0)
                out_ch.ready <= 1'b1;
            else if (ready_mode == 1)
                out_ch.ready <= ($urandom_range(0, 1) == 0);
            else if (ready_mode == 2)
                out_ch.ready <= ($urandom_range(0, 3) == 0);
            else
                out_ch.ready <= ((ready_cyc / 5) % 2 == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            out_item_t want;
            if (expected_fields.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: tag %0d value %h status %0d last %0b",
                             out_ch.field_tag, out_ch.field_value, out_ch.parse_status,
                             out_ch.run_last);
            end
            else
            begin
                want = expected_fields.pop_front();
                if (out_ch.field_tag !== want.field_tag
                    || out_ch.field_value !== want.field_value
                    || out_ch.parse_status !== want.parse_status
                    || out_ch.run_last !== want.run_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected tag %0d value %h status %0d last %0b, got tag %0d value %h status %0d last %0b",
                                 want.field_tag, want.field_value, want.parse_status,
                                 want.run_last, out_ch.field_tag, out_ch.field_value,
                                 out_ch.parse_status, out_ch.run_last);
                end
            end
        end
    end

    task automatic add32(input logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            body_q.push_back(v[8*i +: 8]);
    endtask

    task automatic add64(input logic [63:0] v);
        add32(v[63:32]);
        add32(v[31:0]);
    endtask

    task automatic add_path();
        int len;
        int r;
        int n;
        logic [7:0] b;
        r = $urandom_range(0, 39);
        len = (r == 0) ? 0 : (r == 1) ? PCAP - 1 : (r == 2) ? PCAP : $urandom_range(1, 6);
        add32(len);
        n = (len == PCAP) ? 3 : len;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 59) == 0)
                b = 8'd0;
            body_q.push_back(b);
        end
    endtask

    task automatic add_handle();
        add32(($urandom_range(0, 9) == 0) ? $urandom_range(0, 9) : HBYTES);
        add64({$urandom, $urandom});
    endtask

    task automatic add_raw_string(input int len);
        add32(len);
        for (int i = 0; i < len; i++)
            body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_attrs();
        logic [31:0] flags;
        int cnt;
        flags = {$urandom_range(0, 1) == 1, 27'd0, 4'($urandom_range(0, 15))};
        if ($urandom_range(0, 7) == 0)
            flags = $urandom;
        add32(flags);
        if (flags[0]) add64({$urandom, $urandom});
        if (flags[1]) begin add32($urandom); add32($urandom); end
        if (flags[2]) add32($urandom);
        if (flags[3]) begin add32($urandom); add32($urandom); end
        if (flags[31])
        begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 70000) : $urandom_range(0, 2);
            add32(cnt);
            for (int i = 0; i < cnt && i < 3; i++)
            begin
                add_raw_string($urandom_range(0, 3));
                add_raw_string($urandom_range(0, 3));
            end
        end
    endtask

    task automatic build_request(input logic [7:0] t);
        int dlen;
        body_q.delete();
        body_q.push_back(t);
        add32($urandom);
        case (t)
            T_INIT: ;
            T_OPEN: begin add_path(); add32($urandom); add_attrs(); end
            T_SETSTAT, T_MKDIR: begin add_path(); add_attrs(); end
            T_RENAME, T_SYMLINK: begin add_path(); add_path(); end
            T_LSTAT, T_STAT, T_OPENDIR, T_REMOVE, T_RMDIR, T_REALPATH, T_READLINK:
                add_path();
            T_CLOSE, T_FSTAT, T_READDIR: add_handle();
            T_READ: begin add_handle(); add64({$urandom, $urandom}); add32($urandom); end
            T_WRITE:
            begin
                add_handle();
                add64({$urandom, $urandom});
                dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70000)
                                                     : $urandom_range(0, 5);
                add32(dlen);
                for (int i = 0; i < dlen && i < 6; i++)
                    body_q.push_back(8'($urandom_range(0, 255)));
            end
            T_FSETSTAT: begin add_handle(); add_attrs(); end
            default:
                for (int i = $urandom_range(0, 3); i > 0; i--)
                    body_q.push_back(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 9) == 0)
            for (int i = $urandom_range(1, 3); i > 0; i--)
                body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_bytes(input logic [7:0] pkt[$]);
        in_item_t it;
        foreach (pkt[i])
        begin
            it.in_byte = pkt[i];
            it.buffer_end = (i == pkt.size() - 1);
            pending_bytes.push_back(it);
        end
        bytes_queued += pkt.size();
    endtask

    // Frames body_q; kind selects a framing fault, or none when it is zero.
    task automatic send_framed(input int kind);
        logic [7:0] pkt[$];
        logic [31:0] len;
        int n;
        len = body_q.size();
        case (kind)
            1: len = (len > 1 && $urandom_range(0, 1) == 1) ? len - 1 : len + 1;
            5: len = 0;
            6: len = ($urandom_range(0, 1) == 1) ? max_body + 1 : $urandom;
            default: ;
        endcase
        for (int i = 3; i >= 0; i--)
            pkt.push_back(len[8*i +: 8]);
        if (kind == 4)
        begin
            pkt.delete();
            for (int i = $urandom_range(1, 3); i > 0; i--)
                pkt.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 7)
        begin
            pkt.delete();
            for (int i = $urandom_range(1, 8); i > 0; i--)
                pkt.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind != 5)
        begin
            n = body_q.size();
            if (kind == 2 && n > 1)
                n = n - $urandom_range(1, (n > 3) ? 3 : n - 1);
            for (int i = 0; i < n; i++)
                pkt.push_back(body_q[i]);
            if (kind == 3)
                for (int i = $urandom_range(1, 2); i > 0; i--)
                    pkt.push_back(8'($urandom_range(0, 255)));
        end
        queue_bytes(pkt);
    endtask

    task automatic random_packet();
        int r;
        int kind;
        logic [7:0] t;
        r = $urandom_range(0, 20);
        t = (r < 19) ? 8'(r + 1) : 8'($urandom_range(21, 255));
        if (t == 8'd2 && $urandom_range(0, 1) == 1)
            t = 8'd0;
        build_request(t);
        r = $urandom_range(0, 99);
        kind = (r < 72) ? 0 : (r < 78) ? 1 : (r < 84) ? 2 : (r < 89) ? 3 :
               (r < 92) ? 4 : (r < 95) ? 5 : (r < 97) ? 6 : 7;
        send_framed(kind);
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() > 0 || in_ch.valid || expected_fields.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_body(input logic [31:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_body = v;
        @(posedge clk);
    endtask

    task automatic random_run(input int nbytes);
        int stop_at;
        stop_at = bytes_queued + nbytes;
        while (bytes_queued < stop_at)
            random_packet();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.buffer_end = 1'b0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        hold_seq = 0;
        bytes_queued = 0;
        max_body = MAX_BODY_RESET;
        clear_parse();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int t = 0; t <= 21; t++)
        begin
            build_request(8'(t));
            send_framed(0);
        end
        build_request(T_READ);
        send_framed(4);
        build_request(T_STAT);
        send_framed(5);
        build_request(T_STAT);
        send_framed(6);
        build_request(T_WRITE);
        send_framed(2);
        build_request(T_FSTAT);
        send_framed(3);
        body_q.delete();
        body_q.push_back(T_MKDIR);
        add32(32'hffff_ffff);
        add32(2);
        body_q.push_back(8'h41);
        body_q.push_back(8'h00);
        send_framed(0);
        body_q.delete();
        body_q.push_back(T_CLOSE);
        add32(0);
        add32(HBYTES - 1);
        add64(64'h0102_0304_0506_0708);
        send_framed(0);
        body_q.delete();
        body_q.push_back(T_SETSTAT);
        add32(7);
        add32(0);
        add32(32'h8000_0000);
        add32(32'hffff_ffff);
        send_framed(0);

        repeat (30) @(posedge clk);
        hold_seq++;
        random_run(20);
        write_max_body(32'd1);
        random_run(20);
        write_max_body(32'hffff_ffff);
        random_run(30);
        write_max_body(32'd24);
        random_run(20);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_fields.size() == 0)
            $display("tb_sftp_request_parser OK");
        else
            $display("tb_sftp_request_parser NOT OK");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb_sftp_request_parser NOT OK");
        $finish;
    end

endmodule
